// ===== rtl/core/byte_ring_buffer_with_search_macros.svh =====
// Assertion macros used by the byte ring checker.
`ifndef BYTE_RING_BUFFER_WITH_SEARCH_MACROS_SVH
`define BYTE_RING_BUFFER_WITH_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define BRB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("byte ring check failed");

// Next-cycle implication, disabled while reset is active.
`define BRB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("byte ring check failed");

`endif

// ===== rtl/core/brb_pkg.sv =====
// Shared constants, codes and types of the byte ring buffer.
package brb_pkg;

    localparam int DEPTH_DEF    = 4096;
    localparam int MAX_READ_DEF = 64;
    localparam int ADDR_MAX_W   = 16;
    localparam int IN_TDATA_W   = 128;
    localparam int OUT_TDATA_W  = 72;

    // Request kinds
    localparam logic [2:0] REQ_CLEAR  = 3'd0;
    localparam logic [2:0] REQ_WRITE  = 3'd1;
    localparam logic [2:0] REQ_POP    = 3'd2;
    localparam logic [2:0] REQ_RD_POS = 3'd3;
    localparam logic [2:0] REQ_RD_END = 3'd4;
    localparam logic [2:0] REQ_WSRCH  = 3'd5;
    localparam logic [2:0] REQ_BSRCH  = 3'd6;
    localparam logic [2:0] REQ_SETRD  = 3'd7;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_SHORT    = 2'd2;

    // Access request from the sequencer to the ring memory
    typedef struct packed {
        logic                  we;
        logic [ADDR_MAX_W-1:0] waddr;
        logic [7:0]            wdata;
        logic [ADDR_MAX_W-1:0] raddr;
    } ram_req_t;

endpackage

// ===== rtl/core/byte_ring_buffer_with_search.sv =====
// Top level: request sequencer around the byte ring memory.
//
//  channel  | dir | tdata                                   | tuser     | tlast
//  s_axis   | in  | byte,count,offset,start,pattern,consume,newpos | req_type | -
//  m_axis   | out | out_byte,position,pending               | status    | last_of_run
//
// Clear, write, pop, set and reads with nothing to fetch answer in the next cycle. A read
// fetches one byte at a time, each after the previous has landed and the result register is
// free. Searches fetch one byte per cycle; a word search fetches three bytes more than
// its candidates to fill the window. A search result passes the memory read register,
// then the result register. After reset the memory is zero-filled; no transaction is
// taken meanwhile. A stalled result holds the block; the next request is taken as it leaves.
module byte_ring_buffer_with_search #(
    parameter int DEPTH    = brb_pkg::DEPTH_DEF,
    parameter int MAX_READ = brb_pkg::MAX_READ_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // data_byte, count, offset, start_index, pattern, consume, new_position, zero pad
    input  logic [brb_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // req_type
    input  logic [2:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_byte, position, pending
    output logic [brb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // status
    output logic [1:0]                     m_axis_tuser,
    output logic                           m_axis_tlast
);
    import brb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(MAX_READ + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_WSRCH = 3'd2;
    localparam logic [2:0] S_BSRCH = 3'd3;

    // Unpacked request fields
    logic [2:0]  req_type;
    logic [7:0]  data_byte;
    logic [15:0] count;
    logic [15:0] offset;
    logic [15:0] start_index;
    logic [31:0] pattern;
    logic        consume;
    logic [31:0] new_position;

    assign req_type     = s_axis_tuser;
    assign data_byte    = s_axis_tdata[7:0];
    assign count        = s_axis_tdata[23:8];
    assign offset       = s_axis_tdata[39:24];
    assign start_index  = s_axis_tdata[55:40];
    assign pattern      = s_axis_tdata[87:56];
    assign consume      = s_axis_tdata[88];
    assign new_position = s_axis_tdata[120:89];

    logic [2:0]    state_reg, state_next;
    logic [31:0]   wp_reg, wp_next;
    logic [31:0]   rp_reg, rp_next;
    logic [AW-1:0] fetch_reg, fetch_next;
    logic [LW-1:0] remain_reg, remain_next;
    logic          inflight_reg, inflight_next;
    logic [16:0]   fetch_left_reg, fetch_left_next;
    logic [15:0]   cand_left_reg, cand_left_next;
    logic [31:0]   cand_reg, cand_next;
    logic [1:0]    fill_reg, fill_next;
    logic [31:0]   win_reg, win_next;
    logic [31:0]   pat_reg, pat_next;
    logic [15:0]   limit_reg, limit_next;
    logic [16:0]   issue_idx_reg, issue_idx_next;
    logic [15:0]   cmp_idx_reg, cmp_idx_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          out_last_reg, out_last_next;
    logic [31:0]   out_pos_reg, out_pos_next;
    logic [1:0]    out_status_reg, out_status_next;

    ram_req_t    ram_req;
    logic [7:0]  ram_rdata;
    logic        ram_busy;

    logic               out_free;
    logic               accept;
    logic               issue;
    logic               out_load;
    logic [LW-1:0]      len;
    logic [15:0]        rd_dist;
    logic [31:0]        pend;
    logic signed [32:0] pend_s;
    logic signed [32:0] lim_s;
    logic signed [32:0] cnt_s;
    logic signed [32:0] limit_s;
    logic               too_little;
    logic [15:0]        wn;
    logic [31:0]        win_shift;
    logic [31:0]        rd_base;

    brb_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ram_req),
        .rdata (ram_rdata),
        .busy  (ram_busy)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free && !ram_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Request arithmetic
    always_comb
    begin
        len     = (count > 16'(MAX_READ)) ? LW'(MAX_READ) : count[LW-1:0];
        rd_dist = (offset < 16'(len)) ? 16'(len) : offset;
        pend    = wp_reg - rp_reg;
        pend_s  = {pend[31], pend};
        too_little = $signed({17'd0, rd_dist}) > pend_s;
        lim_s   = pend_s - 33'sd1;
        cnt_s   = $signed({17'd0, count});
        limit_s = (cnt_s < lim_s) ? cnt_s : lim_s;
        wn      = (count > 16'd5) ? (count - 16'd4) : 16'd1;
        win_shift = {win_reg[23:0], ram_rdata};
        rd_base = (req_type == REQ_RD_POS) ? (rp_reg - 32'(offset))
                                           : (wp_reg - 32'(rd_dist));
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        fetch_next      = fetch_reg;
        remain_next     = remain_reg;
        fetch_left_next = fetch_left_reg;
        cand_left_next  = cand_left_reg;
        cand_next       = cand_reg;
        fill_next       = fill_reg;
        win_next        = win_reg;
        pat_next        = pat_reg;
        limit_next      = limit_reg;
        issue_idx_next  = issue_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        out_load        = 1'b0;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_pos_next    = out_pos_reg;
        out_status_next = out_status_reg;
        issue           = 1'b0;
        ram_req.we      = 1'b0;
        ram_req.waddr   = ADDR_MAX_W'(wp_reg[AW-1:0]);
        ram_req.wdata   = data_byte;
        ram_req.raddr   = ADDR_MAX_W'(fetch_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_byte_next   = 8'd0;
                    out_last_next   = 1'b1;
                    out_status_next = ST_OK;
                    unique case (req_type) inside
                        REQ_CLEAR:
                        begin
                            wp_next      = '0;
                            rp_next      = '0;
                            out_pos_next = '0;
                            out_load     = 1'b1;
                        end
                        REQ_WRITE:
                        begin
                            ram_req.we   = 1'b1;
                            wp_next      = wp_reg + 32'd1;
                            out_pos_next = wp_reg + 32'd1;
                            out_load     = 1'b1;
                        end
                        REQ_POP:
                        begin
                            rp_next = rp_reg + 32'(count);
                            if (rp_next == wp_reg)
                            begin
                                wp_next = 32'(wp_reg[AW-1:0]);
                                rp_next = 32'(rp_next[AW-1:0]);
                            end
                            out_pos_next = rp_next;
                            out_load     = 1'b1;
                        end
                        REQ_RD_POS, REQ_RD_END:
                        begin
                            if (req_type == REQ_RD_END && too_little)
                            begin
                                out_status_next = ST_SHORT;
                                out_pos_next    = rp_reg;
                                out_load        = 1'b1;
                            end
                            else
                            begin
                                if (req_type == REQ_RD_END && consume)
                                    rp_next = rp_reg + 32'(len);
                                if (len == '0)
                                begin
                                    out_pos_next = rp_next;
                                    out_load     = 1'b1;
                                end
                                else
                                begin
                                    fetch_next  = rd_base[AW-1:0];
                                    remain_next = len;
                                    state_next  = S_READ;
                                end
                            end
                        end
                        REQ_WSRCH:
                        begin
                            // First window is the four bytes below the newest candidate
                            pat_next        = pattern;
                            cand_next       = wp_reg - 32'd1;
                            cand_left_next  = wn;
                            fetch_left_next = {1'b0, wn} + 17'd3;
                            fetch_next      = wp_reg[AW-1:0] - AW'(2);
                            fill_next       = '0;
                            win_next        = '0;
                            state_next      = S_WSRCH;
                        end
                        REQ_BSRCH:
                        begin
                            if (limit_s <= $signed({17'd0, start_index}))
                            begin
                                out_pos_next    = '1;
                                out_status_next = ST_NOTFOUND;
                                out_load        = 1'b1;
                            end
                            else
                            begin
                                pat_next       = pattern;
                                limit_next     = limit_s[15:0];
                                issue_idx_next = {1'b0, start_index};
                                fetch_next     = rp_reg[AW-1:0] + start_index[AW-1:0];
                                state_next     = S_BSRCH;
                            end
                        end
                        REQ_SETRD:
                        begin
                            rp_next      = new_position;
                            out_pos_next = new_position;
                            out_load     = 1'b1;
                        end
                        default:
                        begin
                            out_load = 1'b0;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                // Fetch one byte at a time, land it in the output register
                if (!inflight_reg && remain_reg != '0 && out_free)
                begin
                    issue       = 1'b1;
                    fetch_next  = fetch_reg + 1'b1;
                    remain_next = remain_reg - 1'b1;
                end
                if (inflight_reg)
                begin
                    out_load        = 1'b1;
                    out_byte_next   = ram_rdata;
                    out_last_next   = (remain_reg == '0);
                    out_pos_next    = rp_reg;
                    out_status_next = ST_OK;
                    if (remain_reg == '0)
                        state_next = S_IDLE;
                end
            end

            S_WSRCH:
            begin
                // Walk backward, sliding a four-byte window
                if (fetch_left_reg != '0)
                begin
                    issue           = 1'b1;
                    fetch_next      = fetch_reg - 1'b1;
                    fetch_left_next = fetch_left_reg - 17'd1;
                end
                if (inflight_reg)
                begin
                    win_next = win_shift;
                    if (fill_reg != 2'd3)
                        fill_next = fill_reg + 2'd1;
                    else if (win_shift == pat_reg)
                    begin
                        out_load        = 1'b1;
                        out_byte_next   = 8'd0;
                        out_last_next   = 1'b1;
                        out_pos_next    = cand_reg;
                        out_status_next = ST_OK;
                        state_next      = S_IDLE;
                    end
                    else if (cand_left_reg == 16'd1)
                    begin
                        out_load        = 1'b1;
                        out_byte_next   = 8'd0;
                        out_last_next   = 1'b1;
                        out_pos_next    = '1;
                        out_status_next = ST_NOTFOUND;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        cand_next      = cand_reg - 32'd1;
                        cand_left_next = cand_left_reg - 16'd1;
                    end
                end
            end

            S_BSRCH:
            begin
                // Walk forward from the start index
                if (issue_idx_reg < {1'b0, limit_reg})
                begin
                    issue          = 1'b1;
                    fetch_next     = fetch_reg + 1'b1;
                    issue_idx_next = issue_idx_reg + 17'd1;
                    cmp_idx_next   = issue_idx_reg[15:0];
                end
                if (inflight_reg)
                begin
                    if (ram_rdata == pat_reg[7:0])
                    begin
                        out_load        = 1'b1;
                        out_byte_next   = 8'd0;
                        out_last_next   = 1'b1;
                        out_pos_next    = 32'(cmp_idx_reg);
                        out_status_next = ST_OK;
                        state_next      = S_IDLE;
                    end
                    else if (cmp_idx_reg == limit_reg - 16'd1)
                    begin
                        out_load        = 1'b1;
                        out_byte_next   = 8'd0;
                        out_last_next   = 1'b1;
                        out_pos_next    = '1;
                        out_status_next = ST_NOTFOUND;
                        state_next      = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        inflight_next  = issue;
        out_valid_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            inflight_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            inflight_reg  <= inflight_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        fetch_reg      <= fetch_next;
        remain_reg     <= remain_next;
        fetch_left_reg <= fetch_left_next;
        cand_left_reg  <= cand_left_next;
        cand_reg       <= cand_next;
        fill_reg       <= fill_next;
        win_reg        <= win_next;
        pat_reg        <= pat_next;
        limit_reg      <= limit_next;
        issue_idx_reg  <= issue_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        out_byte_reg   <= out_byte_next;
        out_last_reg   <= out_last_next;
        out_pos_reg    <= out_pos_next;
        out_status_reg <= out_status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {wp_reg - rp_reg, out_pos_reg, out_byte_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== rtl/core/brb_ram.sv =====
// Byte ring memory with registered read and a zero-fill pass after reset.
module brb_ram #(
    parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  brb_pkg::ram_req_t req,
    output logic [7:0]        rdata,
    output logic              busy
);
    import brb_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rdata_reg;
    logic          busy_reg;
    logic [AW-1:0] clr_addr_reg;

    // Sweep every entry to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == {AW{1'b1}})
                busy_reg <= 1'b0;
        end
    end

    // Write port: fill pass first, then requests
    always_ff @(posedge clk)
    begin
        if (busy_reg)
            mem[clr_addr_reg] <= 8'd0;
        else if (req.we)
            mem[req.waddr[AW-1:0]] <= req.wdata;
    end

    // Read port, registered output
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[req.raddr[AW-1:0]];
    end

    assign rdata = rdata_reg;
    assign busy  = busy_reg;

endmodule

// ===== rtl/core/brb_checker.sv =====
// Port-level checks of the byte ring buffer, bound to the top level.
`include "byte_ring_buffer_with_search_macros.svh"

module brb_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [brb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [2:0]                      s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [brb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]                      m_axis_tuser,
    input logic                            m_axis_tlast
);
    import brb_pkg::*;

    // A stalled result holds
    `BRB_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // A request is only taken when the result register is free
    `BRB_ASSERT_IMP(a_accept_free, clk, rst_n, s_axis_tvalid && s_axis_tready, !m_axis_tvalid || m_axis_tready)

    // A byte write answers in the next cycle with a single ok item
    `BRB_ASSERT_NXT(a_write_resp, clk, rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_WRITE), m_axis_tvalid && m_axis_tlast && (m_axis_tuser == ST_OK))

    // A failed search ends the run and reports minus one
    `BRB_ASSERT_IMP(a_notfound, clk, rst_n, m_axis_tvalid && (m_axis_tuser == ST_NOTFOUND), m_axis_tlast && (m_axis_tdata[39:8] == 32'hFFFF_FFFF))

endmodule

bind byte_ring_buffer_with_search brb_checker u_brb_checker (.*);

// ===== bench/byte_ring_buffer_with_search_tb.sv =====
// Self-checking testbench for the byte ring buffer with search.
module byte_ring_buffer_with_search_tb;
    import brb_pkg::*;

    localparam int RING_DEPTH  = DEPTH_DEF;
    localparam int READ_MAX    = MAX_READ_DEF;
    localparam int STALL_LIMIT = 300000;
    localparam int RANDOM_REQS = 305;

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] count;
        logic [15:0] offset;
        logic [15:0] start_index;
        logic [31:0] pattern;
        logic        consume;
        logic [31:0] new_position;
    } ring_req_t;

    typedef struct {
        logic [7:0]  out_byte;
        logic        last;
        logic [31:0] position;
        logic [1:0]  status;
        logic [31:0] pending;
    } ring_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic [2:0] s_axis_tuser = REQ_CLEAR;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic m_axis_tlast;

    // Shadow copy of the ring and its positions
    logic [7:0]  shadow_ring [RING_DEPTH];
    logic [31:0] shadow_wr;
    logic [31:0] shadow_rd;
    logic [7:0]  last_written;

    ring_result_t expected_results[$];
    int fail_count = 0;
    int req_count = 0;
    int result_count = 0;
    int stall_cycles = 0;
    int ready_hold = 0;
    bit quiet = 1'b0;

    byte_ring_buffer_with_search i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    // Little-endian word held in the four slots below a position
    function automatic logic [31:0] word_below(input logic [31:0] pos);
        logic [31:0] w;
        w = '0;
        for (int j = 0; j < 4; j++)
            w[8*j +: 8] = shadow_ring[(pos + j - 4) % RING_DEPTH];
        return w;
    endfunction

    function automatic void push_result(input logic [7:0] b, input logic last,
                                        input logic [31:0] pos, input logic [1:0] st);
        ring_result_t res;
        res.out_byte = b;
        res.last     = last;
        res.position = pos;
        res.status   = st;
        res.pending  = shadow_wr - shadow_rd;
        expected_results.push_back(res);
    endfunction

    // Apply one request to the shadow state and queue its results
    function automatic void model_request(input ring_req_t r);
        int unsigned len, rd_dist, n;
        logic [31:0] base, cand;
        logic [7:0]  buffer [READ_MAX];
        longint      limit;
        bit          hit;
        len = (r.count > READ_MAX) ? READ_MAX : r.count;
        hit = 1'b0;
        case (r.kind)
            REQ_CLEAR:
            begin
                shadow_wr = '0;
                shadow_rd = '0;
                push_result(8'h00, 1'b1, shadow_wr, ST_OK);
            end
            REQ_WRITE:
            begin
                shadow_ring[shadow_wr % RING_DEPTH] = r.data_byte;
                shadow_wr = shadow_wr + 1;
                push_result(8'h00, 1'b1, shadow_wr, ST_OK);
            end
            REQ_POP:
            begin
                shadow_rd = shadow_rd + r.count;
                if (shadow_rd == shadow_wr)
                begin
                    shadow_wr = shadow_wr % RING_DEPTH;
                    shadow_rd = shadow_rd % RING_DEPTH;
                end
                push_result(8'h00, 1'b1, shadow_rd, ST_OK);
            end
            REQ_RD_POS:
            begin
                if (len == 0)
                    push_result(8'h00, 1'b1, shadow_rd, ST_OK);
                base = shadow_rd - r.offset;
                for (int unsigned i = 0; i < len; i++)
                    push_result(shadow_ring[(base + i) % RING_DEPTH], i + 1 == len,
                                shadow_rd, ST_OK);
            end
            REQ_RD_END:
            begin
                rd_dist = (r.offset < len) ? len : r.offset;
                if (longint'(rd_dist) > longint'($signed(shadow_wr - shadow_rd)))
                    push_result(8'h00, 1'b1, shadow_rd, ST_SHORT);
                else
                begin
                    base = shadow_wr - rd_dist;
                    for (int unsigned i = 0; i < len; i++)
                        buffer[i] = shadow_ring[(base + i) % RING_DEPTH];
                    if (r.consume)
                        shadow_rd = shadow_rd + len;
                    if (len == 0)
                        push_result(8'h00, 1'b1, shadow_rd, ST_OK);
                    for (int unsigned i = 0; i < len; i++)
                        push_result(buffer[i], i + 1 == len, shadow_rd, ST_OK);
                end
            end
            REQ_WSRCH:
            begin
                n = (r.count > 5) ? r.count - 4 : 1;
                for (int unsigned i = 0; i < n && !hit; i++)
                begin
                    cand = shadow_wr - 1 - i;
                    if (word_below(cand) == r.pattern)
                    begin
                        push_result(8'h00, 1'b1, cand, ST_OK);
                        hit = 1'b1;
                    end
                end
                if (!hit)
                    push_result(8'h00, 1'b1, 32'hFFFF_FFFF, ST_NOTFOUND);
            end
            REQ_BSRCH:
            begin
                limit = longint'($signed(shadow_wr - shadow_rd)) - 1;
                if (longint'(r.count) < limit)
                    limit = r.count;
                for (longint idx = r.start_index; idx < limit && !hit; idx++)
                begin
                    if (shadow_ring[(shadow_rd + 32'(idx)) % RING_DEPTH] == r.pattern[7:0])
                    begin
                        push_result(8'h00, 1'b1, 32'(idx), ST_OK);
                        hit = 1'b1;
                    end
                end
                if (!hit)
                    push_result(8'h00, 1'b1, 32'hFFFF_FFFF, ST_NOTFOUND);
            end
            default:
            begin
                shadow_rd = r.new_position;
                push_result(8'h00, 1'b1, shadow_rd, ST_OK);
            end
        endcase
    endfunction

    // Send one request; hold tvalid until the transaction is taken
    task automatic send_req(input ring_req_t r);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.kind;
        s_axis_tdata  <= {7'b0, r.new_position, r.consume, r.pattern, r.start_index,
                          r.offset, r.count, r.data_byte};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        model_request(r);
        if (r.kind == REQ_WRITE)
            last_written = r.data_byte;
        req_count++;
    endtask

    function automatic ring_req_t make_req(input logic [2:0] kind);
        ring_req_t r;
        r.kind = kind;
        r.data_byte = '0;
        r.count = '0;
        r.offset = '0;
        r.start_index = '0;
        r.pattern = '0;
        r.consume = 1'b0;
        r.new_position = '0;
        return r;
    endfunction

    task automatic send_simple(input logic [2:0] kind, input logic [15:0] cnt,
                               input logic [15:0] offs, input logic [31:0] pat);
        ring_req_t r;
        r = make_req(kind);
        r.count = cnt;
        r.offset = offs;
        r.pattern = pat;
        r.data_byte = pat[7:0];
        r.new_position = pat;
        send_req(r);
    endtask

    // Stores, pops and the fold of both positions when they meet
    task automatic test_basic_ops();
        send_simple(REQ_WRITE, 0, 0, 32'h00);
        send_simple(REQ_WRITE, 0, 0, 32'hFF);
        for (int i = 1; i <= 6; i++)
            send_simple(REQ_WRITE, 0, 0, 32'(8'h10 * i + i));
        send_simple(REQ_POP, 2, 0, 0);
        send_simple(REQ_POP, 16'(shadow_wr - shadow_rd), 0, 0);
        for (int i = 0; i < 6; i++)
            send_simple(REQ_WRITE, 0, 0, 32'(8'hA0 + i));
    endtask

    // Zero-length, clamped, short and consuming reads
    task automatic test_reads();
        ring_req_t r;
        send_simple(REQ_RD_POS, 0, 0, 0);
        send_simple(REQ_RD_POS, 16'hFFFF, 16'd6, 0);
        send_simple(REQ_RD_END, 3, 16'hFFFF, 0);
        send_simple(REQ_RD_END, 0, 0, 0);
        r = make_req(REQ_RD_END);
        r.count = 3;
        r.consume = 1'b1;
        send_req(r);
    endtask

    // Word search hit and miss, byte search hit and empty range
    task automatic test_searches();
        ring_req_t r;
        send_simple(REQ_WSRCH, 12, 0, word_below(shadow_wr - 2));
        send_simple(REQ_WSRCH, 0, 0, 32'hDEAD_BEEF);
        send_simple(REQ_BSRCH, 40, 0, 32'(last_written));
        r = make_req(REQ_BSRCH);
        r.count = 40;
        r.start_index = 16'hFFFF;
        send_req(r);
        send_simple(REQ_WSRCH, 16'hFFFF, 0, 32'h1234_5678);
    endtask

    // Wrap of the positions past 2^32 and negative pending counts
    task automatic test_wrap();
        send_simple(REQ_SETRD, 0, 0, shadow_wr + 5);
        send_simple(REQ_BSRCH, 16'hFFFF, 0, 0);
        send_simple(REQ_RD_END, 1, 0, 0);
        send_simple(REQ_SETRD, 0, 0, 32'hFFFF_FFFE);
        send_simple(REQ_POP, 5, 0, 0);
        send_simple(REQ_SETRD, 0, 0, 32'h8000_0000);
        send_simple(REQ_BSRCH, 16'hFFFF, 0, 32'h5A);
        send_simple(REQ_CLEAR, 0, 0, 0);
    endtask

    // Mostly well-formed traffic around the filled region, some noise
    task automatic test_random();
        ring_req_t r;
        int pick;
        for (int k = 0; k < RANDOM_REQS; k++)
        begin
            if (k == RANDOM_REQS - 60)
                quiet = 1'b1;
            pick = $urandom_range(0, 99);
            r = make_req(REQ_WRITE);
            r.data_byte = 8'($urandom_range(0, 255));
            if (pick < 40)
                r.kind = REQ_WRITE;
            else if (pick < 48)
            begin
                r.kind = REQ_POP;
                r.count = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                              : $urandom_range(0, 6));
            end
            else if (pick < 60)
            begin
                r.kind = REQ_RD_POS;
                r.count = 16'($urandom_range(0, 70));
                r.offset = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                               : $urandom_range(0, 80));
            end
            else if (pick < 72)
            begin
                r.kind = REQ_RD_END;
                r.count = 16'($urandom_range(0, 70));
                r.offset = 16'($urandom_range(0, 80));
                r.consume = 1'($urandom_range(0, 1));
            end
            else if (pick < 80)
            begin
                r.kind = REQ_WSRCH;
                r.count = 16'($urandom_range(0, 40));
                r.pattern = ($urandom_range(0, 1) == 1)
                          ? word_below(shadow_wr - $urandom_range(1, 20)) : $urandom();
            end
            else if (pick < 88)
            begin
                r.kind = REQ_BSRCH;
                r.count = 16'($urandom_range(0, 80));
                r.start_index = 16'($urandom_range(0, 20));
                r.pattern = {24'($urandom_range(0, 16777215)),
                             ($urandom_range(0, 2) != 0) ? last_written : 8'($urandom())};
            end
            else if (pick < 93)
            begin
                r.kind = REQ_SETRD;
                r.new_position = ($urandom_range(0, 4) == 0) ? $urandom()
                               : shadow_wr - $urandom_range(0, 30);
            end
            else if (pick < 96)
                r.kind = REQ_CLEAR;
            else
            begin
                r.kind = 3'($urandom_range(0, 7));
                r.count = 16'($urandom_range(0, 65535));
                r.offset = 16'($urandom_range(0, 65535));
                r.start_index = 16'($urandom_range(0, 65535));
                r.pattern = $urandom();
                r.consume = 1'($urandom_range(0, 1));
                r.new_position = $urandom();
                if ((r.kind == REQ_WSRCH || r.kind == REQ_BSRCH) && $urandom_range(0, 3) != 0)
                    r.count = r.count & 16'h00FF;
            end
            send_req(r);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Drive the result side ready with random stall bursts
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold--;
            m_axis_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            ready_hold = $urandom_range(1, 5) - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Compare each result transaction and watch for a hung block
    always @(posedge clk)
    begin
        ring_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            result_count++;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: byte %0h pos %0h", m_axis_tdata[7:0],
                       m_axis_tdata[39:8]);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_axis_tdata[7:0] !== want.out_byte)
                begin
                    $error("out_byte exp %0h got %0h", want.out_byte, m_axis_tdata[7:0]);
                    fail_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last_of_run exp %0b got %0b", want.last, m_axis_tlast);
                    fail_count++;
                end
                if (m_axis_tdata[39:8] !== want.position)
                begin
                    $error("position exp %0h got %0h", want.position, m_axis_tdata[39:8]);
                    fail_count++;
                end
                if (m_axis_tuser !== want.status)
                begin
                    $error("status exp %0d got %0d", want.status, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[71:40] !== want.pending)
                begin
                    $error("pending exp %0h got %0h", want.pending, m_axis_tdata[71:40]);
                    fail_count++;
                end
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < RING_DEPTH; i++)
            shadow_ring[i] = 8'h00;
        shadow_wr = '0;
        shadow_rd = '0;
        last_written = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_ops();
        test_reads();
        test_searches();
        test_wrap();
        test_random();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("covered %0d requests of all eight kinds, %0d result transactions checked",
                 req_count, result_count);
        $display("including clamped and short reads, position wrap and both searches");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/brb_pkg.sv
rtl/core/brb_ram.sv
rtl/core/byte_ring_buffer_with_search.sv
rtl/core/brb_checker.sv
bench/byte_ring_buffer_with_search_tb.sv
